### src/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int GUARD_BITS    = 8;
    localparam int TURN_BITS     = 32;
    localparam int CFG_BITS      = 7;
    localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;

    typedef logic [TURN_BITS-1:0] turn_t;

    typedef struct packed {
        logic       last;
        logic [1:0] quad;
    } meta_t;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    function automatic turn_t atan_turn(input logic [4:0] idx);
        turn_t t;
        case (idx)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

### src/pcc_cordic_stage.sv
`timescale 1ns / 1ps

module pcc_cordic_stage #(
    parameter int XW  = 26,
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        v_in,
    input  logic signed [XW-1:0]        x_in,
    input  logic signed [XW-1:0]        y_in,
    input  pcc_pkg::turn_t              z_in,
    input  pcc_pkg::meta_t              meta_in,
    output logic                        v_out,
    output logic signed [XW-1:0]        x_out,
    output logic signed [XW-1:0]        y_out,
    output pcc_pkg::turn_t              z_out,
    output pcc_pkg::meta_t              meta_out
);

    logic                 v_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    pcc_pkg::turn_t       z_reg, z_next;
    pcc_pkg::meta_t       meta_reg;
    logic signed [XW-1:0] dx, dy;
    pcc_pkg::turn_t       t;

    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        t  = pcc_pkg::atan_turn(5'(IDX));
        if (!z_in[pcc_pkg::TURN_BITS-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - t;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            meta_reg <= meta_in;
        end
    end

    assign v_out    = v_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign meta_out = meta_reg;

endmodule

### src/pcc_cordic.sv
`timescale 1ns / 1ps

module pcc_cordic #(
    parameter int PHASE_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          v_in,
    input  logic [PHASE_BITS-1:0]         phase,
    input  logic                          last_in,
    output logic                          v_out,
    output logic signed [SAMPLE_BITS-1:0] i_out,
    output logic signed [SAMPLE_BITS-1:0] q_out,
    output logic                          last_out
);

    localparam int NS = pcc_pkg::CORDIC_STAGES;
    localparam int GB = pcc_pkg::GUARD_BITS;
    localparam int XW = SAMPLE_BITS + GB + 2;
    localparam longint unsigned MAXV = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam longint unsigned X0_WIDE = (MAXV * pcc_pkg::INV_GAIN_Q32)
                                          >> (pcc_pkg::TURN_BITS - GB);
    localparam logic signed [XW-1:0] X0 = XW'(X0_WIDE);
    localparam logic signed [XW:0] MAXV_W = (XW+1)'(MAXV);
    localparam logic signed [XW:0] MINV_W = -MAXV_W;
    localparam logic signed [XW:0] HALF_W = (XW+1)'(1) <<< (GB - 1);

    pcc_pkg::turn_t       p;
    logic [1:0]           quad;
    pcc_pkg::turn_t       z0;

    logic                 v0_reg;
    pcc_pkg::turn_t       z0_reg;
    pcc_pkg::meta_t       meta0_reg;

    logic                 v_s    [NS+1];
    logic signed [XW-1:0] x_s    [NS+1];
    logic signed [XW-1:0] y_s    [NS+1];
    pcc_pkg::turn_t       z_s    [NS+1];
    pcc_pkg::meta_t       meta_s [NS+1];

    logic signed [XW-1:0] rx, ry;
    logic signed [SAMPLE_BITS-1:0] fi_next, fq_next;

    logic                          vf_reg;
    logic signed [SAMPLE_BITS-1:0] fi_reg, fq_reg;
    logic                          lf_reg;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [XW-1:0] v
    );
        logic signed [XW:0] s;
        logic signed [XW:0] r;
        s = {v[XW-1], v} + HALF_W;
        r = s >>> GB;
        if (r > MAXV_W)
            r = MAXV_W;
        else if (r < MINV_W)
            r = MINV_W;
        return r[SAMPLE_BITS-1:0];
    endfunction

    always_comb
    begin
        p    = {phase, {(pcc_pkg::TURN_BITS - PHASE_BITS){1'b0}}};
        quad = 2'((p + 32'h2000_0000) >> 30);
        z0   = p - {quad, 30'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg         <= z0;
            meta0_reg.quad <= quad;
            meta0_reg.last <= last_in;
        end
    end

    assign v_s[0]    = v0_reg;
    assign x_s[0]    = X0;
    assign y_s[0]    = '0;
    assign z_s[0]    = z0_reg;
    assign meta_s[0] = meta0_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        pcc_cordic_stage #(
            .XW  (XW),
            .IDX (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (v_s[k]),
            .x_in     (x_s[k]),
            .y_in     (y_s[k]),
            .z_in     (z_s[k]),
            .meta_in  (meta_s[k]),
            .v_out    (v_s[k+1]),
            .x_out    (x_s[k+1]),
            .y_out    (y_s[k+1]),
            .z_out    (z_s[k+1]),
            .meta_out (meta_s[k+1])
        );
    end

    always_comb
    begin
        case (meta_s[NS].quad)
            pcc_pkg::QUAD_0:
            begin
                rx = x_s[NS];
                ry = y_s[NS];
            end
            pcc_pkg::QUAD_90:
            begin
                rx = -y_s[NS];
                ry = x_s[NS];
            end
            pcc_pkg::QUAD_180:
            begin
                rx = -x_s[NS];
                ry = -y_s[NS];
            end
            pcc_pkg::QUAD_270:
            begin
                rx = y_s[NS];
                ry = -x_s[NS];
            end
            default:
            begin
                rx = x_s[NS];
                ry = y_s[NS];
            end
        endcase
        fi_next = round_sat(rx);
        fq_next = round_sat(ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vf_reg <= v_s[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fi_reg <= fi_next;
            fq_reg <= fq_next;
            lf_reg <= meta_s[NS].last;
        end
    end

    assign v_out    = vf_reg;
    assign i_out    = fi_reg;
    assign q_out    = fq_reg;
    assign last_out = lf_reg;

endmodule

### src/pcc_repeater.sv
`timescale 1ns / 1ps

module pcc_repeater #(
    parameter int SAMPLE_BITS          = 16,
    parameter int MAX_SAMPLES_PER_CHIP = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pcc_pkg::CFG_BITS-1:0]    samples_per_chip,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_i,
    input  logic signed [SAMPLE_BITS-1:0]   s_q,
    input  logic                            s_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic signed [SAMPLE_BITS-1:0]   q_sample,
    output logic                            last_of_chip,
    output logic                            last_of_code
);

    localparam int CNT_W = (MAX_SAMPLES_PER_CHIP > 1) ? $clog2(MAX_SAMPLES_PER_CHIP) : 1;
    localparam logic [pcc_pkg::CFG_BITS-1:0] MAX_N = pcc_pkg::CFG_BITS'(MAX_SAMPLES_PER_CHIP);

    logic                          valid_reg, valid_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              nm1_reg, nm1_next;
    logic signed [SAMPLE_BITS-1:0] i_reg, q_reg;
    logic                          code_reg;
    logic                          fin;
    logic                          load;
    logic [CNT_W-1:0]              nm1_load;

    always_comb
    begin
        fin     = (cnt_reg == nm1_reg);
        s_ready = !valid_reg || (out_ready && fin);
        load    = s_valid && s_ready;

        if (samples_per_chip == '0)
            nm1_load = '0;
        else if (samples_per_chip > MAX_N)
            nm1_load = CNT_W'(MAX_N - 1'b1);
        else
            nm1_load = CNT_W'(samples_per_chip - 1'b1);

        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        nm1_next   = nm1_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
            nm1_next   = nm1_load;
        end
        else if (valid_reg && out_ready)
        begin
            if (fin)
                valid_next = 1'b0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            nm1_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            nm1_reg   <= nm1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            i_reg    <= s_i;
            q_reg    <= s_q;
            code_reg <= s_last;
        end
    end

    assign out_valid    = valid_reg;
    assign i_sample     = i_reg;
    assign q_sample     = q_reg;
    assign last_of_chip = fin;
    assign last_of_code = fin && code_reg;

endmodule

### src/phase_code_chip_sampler.sv
`timescale 1ns / 1ps
// Path: input register, CORDIC stage registers, rounding output register, repeater register.
// Throughput: one chip per cycle at one sample per chip while out_ready is high; otherwise
// the output repeat counter sends each chip samples_per_chip times, 0 counting as one.
// Stall: the input, CORDIC stage and output registers hold while the repeater cannot take a sample.
// Reset: asynchronous, active low; clears valid bits and counters, repeat count 1.

module phase_code_chip_sampler #(
    parameter int PHASE_BITS           = 16,
    parameter int SAMPLE_BITS          = 16,
    parameter int MAX_SAMPLES_PER_CHIP = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pcc_pkg::CFG_BITS-1:0]    cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [PHASE_BITS-1:0]           chip_phase,
    input  logic                            last_chip,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic signed [SAMPLE_BITS-1:0]   q_sample,
    output logic                            last_of_chip,
    output logic                            last_of_code
);

    logic [pcc_pkg::CFG_BITS-1:0]  spc_reg;
    logic                          en;
    logic                          c_valid;
    logic                          c_ready;
    logic signed [SAMPLE_BITS-1:0] c_i, c_q;
    logic                          c_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg <= pcc_pkg::CFG_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            spc_reg <= cfg_wr_data;
        end
    end

    // advance the whole pipe unless the tail sample is blocked
    assign en       = !c_valid || c_ready;
    assign in_ready = en;

    pcc_cordic #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (in_valid),
        .phase    (chip_phase),
        .last_in  (last_chip),
        .v_out    (c_valid),
        .i_out    (c_i),
        .q_out    (c_q),
        .last_out (c_last)
    );

    pcc_repeater #(
        .SAMPLE_BITS          (SAMPLE_BITS),
        .MAX_SAMPLES_PER_CHIP (MAX_SAMPLES_PER_CHIP)
    ) u_repeater (
        .clk              (clk),
        .rst_n            (rst_n),
        .samples_per_chip (spc_reg),
        .s_valid          (c_valid),
        .s_ready          (c_ready),
        .s_i              (c_i),
        .s_q              (c_q),
        .s_last           (c_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .i_sample         (i_sample),
        .q_sample         (q_sample),
        .last_of_chip     (last_of_chip),
        .last_of_code     (last_of_code)
    );

endmodule

### src/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic signed [SAMPLE_BITS-1:0] q_sample,
    input logic                          last_of_chip,
    input logic                          last_of_code
);

    localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(i_sample) && $stable(q_sample)
            && $stable(last_of_chip) && $stable(last_of_code))
        else $error("stalled output sample changed");

    a_code_in_chip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_code |-> last_of_chip)
        else $error("end of code flagged off the last repeat");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (i_sample != MINV) && (q_sample != MINV))
        else $error("sample outside symmetric range");

    a_repeat_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_chip |=>
            out_valid && $stable(i_sample) && $stable(q_sample))
        else $error("repeat of a chip changed or went missing");

endmodule

bind phase_code_chip_sampler pcc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pcc_checker (.*);
